/* hdl/mlfq_pkg.sv */
// Shared types and constants for the three-level feedback scheduler.
package mlfq_pkg;
	localparam int unsigned LEVELS = 3;
	localparam int MAX_PROCS = 128;
	localparam logic [15:0] TOP_Q_RESET = 16'd8;
	localparam logic [15:0] MID_Q_RESET = 16'd16;
	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic REG_TOP_Q = 1'b0;
	localparam logic REG_MID_Q = 1'b1;

	typedef struct packed {
		logic        valid;
		logic [6:0]  id;
		logic [1:0]  level;
		logic        fin;
		logic        dem;
		logic [31:0] now;
		logic [31:0] tat;
		logic [31:0] wt;
		logic [31:0] rsp;
	} result_t;
endpackage

/* hdl/mlfq_three_level_scheduler.sv */
// Top level of the three-level feedback scheduler: control, queues and process table.
// Arrival: busy in ST_ARR, then back to idle.
// Tick: FIFO head read, table read, writeback (ST_SEL, ST_RD, ST_WB), with the strobe registered in
// ST_WB; an idle tick strobes from ST_SEL. A new start is taken only while the block is idle.
// Reset clears time, pointers, activity flags and quanta to defaults; memories are not cleared.
// Results are strobed for one cycle and cannot be stalled.
module mlfq_three_level_scheduler
	import mlfq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [6:0]  proc_id,
	input  logic [1:0]  entry_level,
	input  logic [15:0] burst_len,
	output logic        strobe,
	output logic        ran_valid,
	output logic [6:0]  ran_id,
	output logic [1:0]  ran_level,
	output logic        finished,
	output logic        demoted,
	output logic [31:0] now_time,
	output logic [31:0] turnaround,
	output logic [31:0] wait_total,
	output logic [31:0] response
);
	localparam int IW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_ARR, ST_SEL, ST_RD, ST_WB} state_t;
	state_t state_q;

	logic [15:0] top_q_q, mid_q_q;
	logic [31:0] clk_cnt_q;
	logic [MAX_PROCS-1:0] active_q, started_q;
	logic [IW-1:0] head_q [LEVELS];
	logic [IW-1:0] tail_q [LEVELS];
	logic [CW-1:0] cnt_q [LEVELS];
	logic [15:0] slice_q [2];

	logic [6:0]  fifo_mem [LEVELS*MAX_PROCS];
	logic [31:0] arr_mem [MAX_PROCS];
	logic [15:0] bur_mem [MAX_PROCS];
	logic [15:0] rem_mem [MAX_PROCS];
	logic [31:0] rsp_mem [MAX_PROCS];

	logic [6:0]  in_id_q;
	logic [1:0]  in_lv_q;
	logic [15:0] in_bur_q;
	logic [1:0]  lv_q;
	logic [IW-1:0] pid_q;
	logic [6:0] fifo_rd;
	logic [31:0] arr_rd, rsp_rd;
	logic [15:0] bur_rd, rem_rd;
	result_t res_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_MID_Q)
			prdata = {16'd0, mid_q_q};
		else
			prdata = {16'd0, top_q_q};
	end

	logic accept;
	assign accept = start && !busy;

	logic [1:0] sel_lv;
	logic sel_any;
	always_comb begin
		sel_any = 1'b1;
		sel_lv = 2'd0;
		priority if (cnt_q[2] != '0) sel_lv = 2'd2;
		else if (cnt_q[1] != '0) sel_lv = 2'd1;
		else if (cnt_q[0] != '0) sel_lv = 2'd0;
		else sel_any = 1'b0;
	end

	function automatic logic [IW-1:0] inc_ptr(input logic [IW-1:0] p);
		logic [IW-1:0] r;
		r = (p == IW'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	function automatic logic [$clog2(LEVELS*MAX_PROCS)-1:0] faddr(
		input logic [1:0] lv, input logic [IW-1:0] p);
		logic [$clog2(LEVELS*MAX_PROCS)-1:0] r;
		r = $clog2(LEVELS*MAX_PROCS)'(lv) * $clog2(LEVELS*MAX_PROCS)'(MAX_PROCS)
			+ $clog2(LEVELS*MAX_PROCS)'(p);
		return r;
	endfunction

	// arrival legality, evaluated in ST_ARR on registered inputs
	logic arr_ok;
	assign arr_ok = (in_lv_q != 2'd3) && (in_bur_q != 16'd0)
		&& ({1'b0, in_id_q} < 8'(MAX_PROCS))
		&& !active_q[in_id_q[IW-1:0]]
		&& (cnt_q[in_lv_q] != CW'(MAX_PROCS));

	// writeback math
	logic [15:0] rem_new, q_eff_m1, used;
	logic [31:0] now_new, tat_c, rsp_c;
	logic fin_c, dem_c;
	always_comb begin
		now_new = clk_cnt_q;
		rem_new = rem_rd - 16'd1;
		fin_c = (rem_new == 16'd0);
		used = slice_q[~lv_q[0]] + 16'd1;
		q_eff_m1 = ((lv_q == 2'd2) ? top_q_q : mid_q_q) - 16'd1;
		// used >= q with q==0 meaning 65536: used-1 >= q-1 over 16 bits
		dem_c = !fin_c && (lv_q != 2'd0) && ((used - 16'd1) >= q_eff_m1);
		rsp_c = started_q[pid_q] ? rsp_rd : (clk_cnt_q - 32'd1 - arr_rd);
		tat_c = now_new - arr_rd;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEL)
			fifo_rd <= fifo_mem[faddr(sel_lv, head_q[sel_lv])];
		if (state_q == ST_RD) begin
			arr_rd <= arr_mem[fifo_rd[IW-1:0]];
			bur_rd <= bur_mem[fifo_rd[IW-1:0]];
			rem_rd <= rem_mem[fifo_rd[IW-1:0]];
			rsp_rd <= rsp_mem[fifo_rd[IW-1:0]];
		end
		if (state_q == ST_ARR && arr_ok) begin
			fifo_mem[faddr(in_lv_q, tail_q[in_lv_q])] <= in_id_q;
			arr_mem[in_id_q[IW-1:0]] <= clk_cnt_q;
			bur_mem[in_id_q[IW-1:0]] <= in_bur_q;
			rem_mem[in_id_q[IW-1:0]] <= in_bur_q;
		end
		if (state_q == ST_WB) begin
			rem_mem[pid_q] <= rem_new;
			if (!started_q[pid_q])
				rsp_mem[pid_q] <= rsp_c;
			if (dem_c)
				fifo_mem[faddr(lv_q - 2'd1, tail_q[lv_q - 2'd1])] <= 7'(pid_q);
		end
		if (accept) begin
			in_id_q <= proc_id;
			in_lv_q <= entry_level;
			in_bur_q <= burst_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q_q <= TOP_Q_RESET;
			mid_q_q <= MID_Q_RESET;
			clk_cnt_q <= '0;
			active_q <= '0;
			started_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			slice_q[0] <= '0;
			slice_q[1] <= '0;
			lv_q <= '0;
			pid_q <= '0;
			res_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == REG_TOP_Q && paddr[1:0] == 2'b00)
					top_q_q <= pwdata[15:0];
				else if (paddr[2] == REG_MID_Q && paddr[1:0] == 2'b00)
					mid_q_q <= pwdata[15:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= (func == FUNC_TICK) ? ST_SEL : ST_ARR;
				end
				ST_ARR: begin
					if (arr_ok) begin
						active_q[in_id_q[IW-1:0]] <= 1'b1;
						started_q[in_id_q[IW-1:0]] <= 1'b0;
						tail_q[in_lv_q] <= inc_ptr(tail_q[in_lv_q]);
						cnt_q[in_lv_q] <= cnt_q[in_lv_q] + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SEL: begin
					clk_cnt_q <= clk_cnt_q + 32'd1;
					lv_q <= sel_lv;
					if (sel_any) begin
						state_q <= ST_RD;
					end else begin
						res_q <= result_t'{now: clk_cnt_q + 32'd1, default: '0};
						strobe <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					pid_q <= fifo_rd[IW-1:0];
					state_q <= ST_WB;
				end
				ST_WB: begin
					started_q[pid_q] <= 1'b1;
					res_q.valid <= 1'b1;
					res_q.id <= 7'(pid_q);
					res_q.level <= lv_q;
					res_q.fin <= fin_c;
					res_q.dem <= dem_c;
					res_q.now <= now_new;
					res_q.tat <= fin_c ? tat_c : 32'd0;
					res_q.wt <= fin_c ? (tat_c - {16'd0, bur_rd}) : 32'd0;
					res_q.rsp <= fin_c ? rsp_c : 32'd0;
					strobe <= 1'b1;
					if (fin_c) begin
						active_q[pid_q] <= 1'b0;
						head_q[lv_q] <= inc_ptr(head_q[lv_q]);
						cnt_q[lv_q] <= cnt_q[lv_q] - 1'b1;
						if (lv_q != 2'd0)
							slice_q[~lv_q[0]] <= '0;
					end else if (dem_c) begin
						head_q[lv_q] <= inc_ptr(head_q[lv_q]);
						cnt_q[lv_q] <= cnt_q[lv_q] - 1'b1;
						tail_q[lv_q - 2'd1] <= inc_ptr(tail_q[lv_q - 2'd1]);
						cnt_q[lv_q - 2'd1] <= cnt_q[lv_q - 2'd1] + 1'b1;
						slice_q[~lv_q[0]] <= '0;
					end else if (lv_q != 2'd0) begin
						slice_q[~lv_q[0]] <= used;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ran_valid = res_q.valid;
	assign ran_id = res_q.id;
	assign ran_level = res_q.level;
	assign finished = res_q.fin;
	assign demoted = res_q.dem;
	assign now_time = res_q.now;
	assign turnaround = res_q.tat;
	assign wait_total = res_q.wt;
	assign response = res_q.rsp;

	a_fin_dem: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(finished && demoted)) else $error("finish and demote together");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !ran_valid) |-> (!finished && !demoted && ran_id == 7'd0))
		else $error("idle tick carries data");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("strobe without work");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CW'(MAX_PROCS)) && (cnt_q[1] <= CW'(MAX_PROCS))
		&& (cnt_q[2] <= CW'(MAX_PROCS))) else $error("queue count overflow");
endmodule

/* tb/sv/tb_mlfq_three_level_scheduler.sv */
// Self-checking testbench for the three-level feedback scheduler: directed, quantum, random and long-burst tests.
module tb_mlfq_three_level_scheduler;
	import mlfq_pkg::*;

	localparam int NPROC = MAX_PROCS;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        func;
	logic [6:0]  proc_id;
	logic [1:0]  entry_level;
	logic [15:0] burst_len;
	logic        strobe, ran_valid, finished, demoted;
	logic [6:0]  ran_id;
	logic [1:0]  ran_level;
	logic [31:0] now_time, turnaround, wait_total, response;

	mlfq_three_level_scheduler i_dut (.*);

	// scheduler shadow state
	logic [31:0] sched_now;
	logic [31:0] arr_stamp [NPROC];
	logic [15:0] burst_of [NPROC];
	logic [15:0] left_of [NPROC];
	logic [31:0] first_run [NPROC];
	bit          is_active [NPROC];
	bit          has_run [NPROC];
	logic [6:0]  lvl_fifo [3][NPROC];
	int          q_head [3];
	int          q_tail [3];
	int          q_cnt [3];
	int          slice_used [2];
	logic [15:0] top_q, mid_q;

	result_t tick_results [$];
	int      errors;
	int      cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic sched_reset();
		sched_now = '0;
		top_q = TOP_Q_RESET;
		mid_q = MID_Q_RESET;
		for (int i = 0; i < NPROC; i++) begin
			is_active[i] = 0;
			has_run[i] = 0;
		end
		for (int l = 0; l < 3; l++) begin
			q_head[l] = 0;
			q_tail[l] = 0;
			q_cnt[l] = 0;
		end
		slice_used[0] = 0;
		slice_used[1] = 0;
	endtask

	function automatic bit fifo_push(int l, logic [6:0] id);
		if (q_cnt[l] >= NPROC) return 0;
		lvl_fifo[l][q_tail[l]] = id;
		q_tail[l] = (q_tail[l] + 1) % NPROC;
		q_cnt[l]++;
		return 1;
	endfunction

	function automatic void fifo_pop(int l);
		if (q_cnt[l] == 0) return;
		q_head[l] = (q_head[l] + 1) % NPROC;
		q_cnt[l]--;
	endfunction

	task automatic schedule_item(logic f, logic [6:0] id, logic [1:0] lv, logic [15:0] bl);
		result_t r;
		int l;
		logic [6:0] pid;
		logic [31:0] q, used;
		r = '0;
		if (f == FUNC_ARRIVE) begin
			if (lv > 2 || bl == 0 || is_active[id]) return;
			if (!fifo_push(lv, id)) return;
			is_active[id] = 1;
			has_run[id] = 0;
			arr_stamp[id] = sched_now;
			burst_of[id] = bl;
			left_of[id] = bl;
			return;
		end
		l = q_cnt[2] != 0 ? 2 : q_cnt[1] != 0 ? 1 : q_cnt[0] != 0 ? 0 : -1;
		r.now = sched_now + 1;
		if (l >= 0) begin
			pid = lvl_fifo[l][q_head[l]];
			if (!has_run[pid]) begin
				has_run[pid] = 1;
				first_run[pid] = sched_now - arr_stamp[pid];
			end
			left_of[pid] = left_of[pid] - 16'd1;
			r.valid = 1'b1;
			r.id = pid;
			r.level = l[1:0];
			if (left_of[pid] == 0) begin
				r.fin = 1'b1;
				is_active[pid] = 0;
				fifo_pop(l);
				if (l > 0) slice_used[l-1] = 0;
				r.tat = r.now - arr_stamp[pid];
				r.wt = r.tat - {16'd0, burst_of[pid]};
				r.rsp = first_run[pid];
			end else if (l > 0) begin
				q = (l == 2) ? {16'd0, top_q} : {16'd0, mid_q};
				if (q == 0) q = 32'd65536;
				used = slice_used[l-1] + 1;
				if (used >= q) begin
					r.dem = 1'b1;
					slice_used[l-1] = 0;
					fifo_pop(l);
					void'(fifo_push(l - 1, pid));
				end else begin
					slice_used[l-1] = used;
				end
			end
		end
		sched_now = r.now;
		tick_results = {tick_results, r};
	endtask

	always @(posedge clk) begin
		result_t w;
		if (arst_n && strobe) begin
			if (tick_results.size() == 0) begin
				report("unexpected beat", {31'd0, ran_valid}, 32'd0);
			end else begin
				w = tick_results.pop_front();
				if (ran_valid !== w.valid) report("ran_valid", 32'(ran_valid), 32'(w.valid));
				if (ran_id !== w.id) report("ran_id", 32'(ran_id), 32'(w.id));
				if (ran_level !== w.level) report("ran_level", 32'(ran_level), 32'(w.level));
				if (finished !== w.fin) report("finished", 32'(finished), 32'(w.fin));
				if (demoted !== w.dem) report("demoted", 32'(demoted), 32'(w.dem));
				if (now_time !== w.now) report("now_time", now_time, w.now);
				if (turnaround !== w.tat) report("turnaround", turnaround, w.tat);
				if (wait_total !== w.wt) report("wait_total", wait_total, w.wt);
				if (response !== w.rsp) report("response", response, w.rsp);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("TEST FAILED");
			$finish;
		end
	end

	int idle_pct;

	// called at a rising edge; returns at the edge that accepted the beat
	task automatic send_item(logic f, logic [6:0] id, logic [1:0] lv, logic [15:0] bl);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		proc_id <= id;
		entry_level <= lv;
		burst_len <= bl;
		@(posedge clk);
		while (busy) @(posedge clk);
		schedule_item(f, id, lv, bl);
	endtask

	task automatic tick();
		send_item(FUNC_TICK, 7'($urandom), 2'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tick_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic regsel, logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {regsel, 2'b00};
		pwdata <= {16'($urandom_range(65535)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (regsel == REG_TOP_Q) top_q = val;
		else mid_q = val;
	endtask

	task automatic test_directed();
		tick();
		send_item(FUNC_ARRIVE, 7'd0, 2'd2, 16'd3);
		send_item(FUNC_ARRIVE, 7'd127, 2'd1, 16'd2);
		send_item(FUNC_ARRIVE, 7'd5, 2'd0, 16'd1);
		send_item(FUNC_ARRIVE, 7'd0, 2'd1, 16'd9);
		send_item(FUNC_ARRIVE, 7'd9, 2'd3, 16'd4);
		send_item(FUNC_ARRIVE, 7'd10, 2'd2, 16'd0);
		repeat (8) tick();
		send_item(FUNC_ARRIVE, 7'd42, 2'd0, 16'd2);
		repeat (3) tick();
	endtask

	task automatic test_quantum(logic [15:0] tq, logic [15:0] mq);
		drain();
		write_reg(REG_TOP_Q, tq);
		write_reg(REG_MID_Q, mq);
		send_item(FUNC_ARRIVE, 7'd1, 2'd2, 16'd5);
		send_item(FUNC_ARRIVE, 7'd2, 2'd2, 16'd4);
		send_item(FUNC_ARRIVE, 7'd3, 2'd1, 16'd3);
		repeat (14) tick();
	endtask

	task automatic test_quantum_lowered();
		drain();
		write_reg(REG_TOP_Q, 16'd8);
		send_item(FUNC_ARRIVE, 7'd20, 2'd2, 16'd12);
		repeat (5) tick();
		drain();
		write_reg(REG_TOP_Q, 16'd2);
		repeat (10) tick();
	endtask

	task automatic test_random(int pct, int n);
		logic [15:0] bl;
		logic [1:0]  lv;
		idle_pct = pct;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 40) begin
				lv = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
				bl = ($urandom_range(24) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
				send_item(FUNC_ARRIVE, 7'($urandom), lv, bl);
			end else begin
				tick();
			end
		end
		idle_pct = 0;
	endtask

	task automatic test_long_burst();
		drain();
		send_item(FUNC_ARRIVE, 7'd127, 2'd0, 16'hFFFF);
		send_item(FUNC_ARRIVE, 7'd85, 2'd2, 16'h5555);
		send_item(FUNC_ARRIVE, 7'd42, 2'd1, 16'hAAAA);
		repeat (6) tick();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		func = FUNC_ARRIVE;
		proc_id = '0;
		entry_level = '0;
		burst_len = '0;
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		sched_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_quantum(16'd1, 16'd65535);
		test_quantum(16'd0, 16'd1);
		test_quantum(16'd65535, 16'd0);
		test_quantum_lowered();
		test_quantum(16'd2, 16'd3);
		test_random(0, 80);
		test_random(86, 80);
		drain();
		write_reg(REG_TOP_Q, 16'd4);
		write_reg(REG_MID_Q, 16'd6);
		test_random(25, 80);
		test_random(0, 80);
		test_long_burst();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && tick_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
